/* src/als_pkg.sv */
// Shared types, constants and register codes of the addressable LED serialiser.
package als_pkg;

  localparam int MAX_LEDS_DEF   = 16;
  localparam int COLOR_BITS_DEF = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEDS       = 3'd4;

  localparam logic [15:0] ZERO_HIGH_RST  = 16'd20;
  localparam logic [15:0] ONE_HIGH_RST   = 16'd40;
  localparam logic [15:0] BIT_PERIOD_RST = 16'd63;
  localparam logic [15:0] LATCH_RST      = 16'd1500;
  localparam logic [4:0]  LEDS_RST       = 5'd16;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
  localparam logic [23:0] RESET_COLOR    = 24'hFFFFFF;

  typedef struct packed {
    logic        start_frame;
    logic        write_enable;
    logic [3:0]  write_index;
    logic [23:0] write_color;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic sending;
    logic ready_to_show;
    logic frame_done;
  } out_item_t;

endpackage

/* src/als_stream_if.sv */
// Valid/ready stream channel carrying one item per transfer.
interface als_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/als_cfg_if.sv */
// Configuration write channel carrying a register index and write data.
interface als_cfg_if;
  import als_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/als_pixel_store.sv */
// Pixel colour memory with registered read, per-entry valid bits and write forwarding.
module als_pixel_store #(
  parameter int DEPTH = als_pkg::MAX_LEDS_DEF,
  parameter int WIDTH = als_pkg::COLOR_BITS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_next,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_word
);
  import als_pkg::*;

  localparam logic [WIDTH-1:0] BLANK = WIDTH'(RESET_COLOR);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] mem_q;
  logic [WIDTH-1:0] hit_data_q;
  logic             valid_q;
  logic             hit_q;
  logic [WIDTH-1:0] stored_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr_next];
    hit_data_q <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr_next];
      hit_q   <= wr_en && (wr_addr == rd_addr_next);
    end
  end

  // An entry never written reads as the reset colour.
  assign stored_word = hit_q ? hit_data_q : (valid_q ? mem_q : BLANK);
  assign rd_word = (wr_en && (wr_addr == rd_addr)) ? wr_data : stored_word;

endmodule

/* src/addressable_led_serializer.sv */
// Top level of the addressable LED serialiser: bit timing, frame control and output stage.
// Each accepted item is one tick; its result enters a two-entry output stage and is
// offered from the next cycle on, so one item is taken every cycle while results drain.
// The next pixel word is fetched ahead of its use through the pixel store's registered read.
// Reset is synchronous, clears frame state and the output stage and loads register defaults;
// every pixel entry then reads as full white until written, held by one valid bit per entry.
module addressable_led_serializer #(
  parameter int MAX_LEDS   = als_pkg::MAX_LEDS_DEF,
  parameter int COLOR_BITS = als_pkg::COLOR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  als_stream_if.sink   pixel_in,
  als_stream_if.source result_out,
  als_cfg_if.sink      cfg
);
  import als_pkg::*;

  localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int PC_W  = $clog2(MAX_LEDS + 1);
  localparam int NP_W  = (PC_W > 5) ? PC_W : 5;
  localparam int BC_W  = $clog2(COLOR_BITS);

  logic [15:0] zero_high;
  logic [15:0] one_high;
  logic [15:0] bit_period;
  logic [15:0] latch_cycles;
  logic [4:0]  leds_in_use;

  logic [COLOR_BITS-1:0] shift_word, shift_word_next;
  logic [BC_W-1:0]       bit_count, bit_count_next;
  logic [PC_W-1:0]       pixel_count, pixel_count_next;
  logic [15:0]           cycle_count, cycle_count_next;
  logic [15:0]           latch_count, latch_count_next;
  logic                  busy, busy_next;
  logic                  start_pending, start_pending_next;

  logic                  accept;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [COLOR_BITS-1:0] wr_data;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      rd_addr_d;
  logic [COLOR_BITS-1:0] load_word;
  logic [NP_W-1:0]       npix;
  out_item_t             res;

  out_item_t q0, q1;
  logic [1:0] out_count;
  logic       pop;

  function automatic logic [IDX_W-1:0] next_addr(input logic b, input logic [PC_W-1:0] p);
    logic [PC_W-1:0] inc;
    inc = p + PC_W'(1);
    if (b && (32'(inc) < 32'(MAX_LEDS))) begin
      return IDX_W'(inc);
    end
    return '0;
  endfunction

  assign pixel_in.ready = !rst && (out_count != 2'd2);
  assign accept = pixel_in.valid && pixel_in.ready;
  assign wr_en = accept && pixel_in.data.write_enable &&
                 (32'(pixel_in.data.write_index) < 32'(MAX_LEDS));
  assign wr_addr = IDX_W'(pixel_in.data.write_index);
  assign wr_data = COLOR_BITS'(pixel_in.data.write_color);

  assign rd_addr = next_addr(busy, pixel_count);
  assign rd_addr_d = rst ? '0 :
                     (accept ? next_addr(busy_next, pixel_count_next) : rd_addr);

  als_pixel_store #(
    .DEPTH(MAX_LEDS),
    .WIDTH(COLOR_BITS),
    .AW   (IDX_W)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr_next(rd_addr_d),
    .rd_addr     (rd_addr),
    .rd_word     (load_word)
  );

  always_comb begin
    npix = (leds_in_use == 5'd0) ? NP_W'(1) : NP_W'(leds_in_use);
    if (32'(npix) > 32'(MAX_LEDS)) begin
      npix = NP_W'(MAX_LEDS);
    end
  end

  always_comb begin
    logic            gap_ok;
    logic [15:0]     period;
    logic [15:0]     high;
    logic [16:0]     cc_inc;
    logic [PC_W-1:0] pc_inc;
    shift_word_next    = shift_word;
    bit_count_next     = bit_count;
    pixel_count_next   = pixel_count;
    cycle_count_next   = cycle_count;
    latch_count_next   = latch_count;
    busy_next          = busy;
    start_pending_next = start_pending | pixel_in.data.start_frame;
    res                = '0;
    gap_ok             = latch_count >= latch_cycles;
    period             = '0;
    high               = '0;
    cc_inc             = '0;
    pc_inc             = '0;

    if (!busy) begin
      if (gap_ok && start_pending_next) begin
        busy_next          = 1'b1;
        start_pending_next = 1'b0;
        pixel_count_next   = '0;
        bit_count_next     = '0;
        cycle_count_next   = '0;
        shift_word_next    = load_word;
      end else begin
        res.ready_to_show = gap_ok;
        if (latch_count != COUNT_MAX) begin
          latch_count_next = latch_count + 16'd1;
        end
      end
    end

    if (busy_next) begin
      period = (bit_period == 16'd0) ? 16'd1 : bit_period;
      high = shift_word_next[COLOR_BITS-1] ? one_high : zero_high;
      res.sending = 1'b1;
      res.line_level = cycle_count_next < high;
      cc_inc = {1'b0, cycle_count_next} + 17'd1;
      if (cc_inc >= {1'b0, period}) begin
        cycle_count_next = '0;
        shift_word_next = shift_word_next << 1;
        if (({1'b0, bit_count_next} + (BC_W+1)'(1)) >= (BC_W+1)'(COLOR_BITS)) begin
          bit_count_next = '0;
          pc_inc = pixel_count_next + PC_W'(1);
          if (NP_W'(pc_inc) >= npix) begin
            res.frame_done   = 1'b1;
            busy_next        = 1'b0;
            pixel_count_next = '0;
            latch_count_next = '0;
          end else begin
            pixel_count_next = pc_inc;
            shift_word_next  = load_word;
          end
        end else begin
          bit_count_next = bit_count_next + BC_W'(1);
        end
      end else begin
        cycle_count_next = cc_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count     <= '0;
      pixel_count   <= '0;
      cycle_count   <= '0;
      latch_count   <= '0;
      busy          <= 1'b0;
      start_pending <= 1'b0;
      shift_word    <= '0;
    end else if (accept) begin
      bit_count     <= bit_count_next;
      pixel_count   <= pixel_count_next;
      cycle_count   <= cycle_count_next;
      latch_count   <= latch_count_next;
      busy          <= busy_next;
      start_pending <= start_pending_next;
      shift_word    <= shift_word_next;
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_high    <= ZERO_HIGH_RST;
      one_high     <= ONE_HIGH_RST;
      bit_period   <= BIT_PERIOD_RST;
      latch_cycles <= LATCH_RST;
      leds_in_use  <= LEDS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ZERO_HIGH:  zero_high    <= cfg.data;
        REG_ONE_HIGH:   one_high     <= cfg.data;
        REG_BIT_PERIOD: bit_period   <= cfg.data;
        REG_LATCH:      latch_cycles <= cfg.data;
        REG_LEDS:       leds_in_use  <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  // Two-entry output stage so that a waiting result does not hold back the next transfer.
  assign pop = result_out.valid && result_out.ready;
  assign result_out.valid = (out_count != 2'd0);
  assign result_out.data = q0;

  always_ff @(posedge clk) begin
    if (pop) begin
      q0 <= (accept && (out_count == 2'd1)) ? res : q1;
    end else if (accept && (out_count == 2'd0)) begin
      q0 <= res;
    end
    if (accept && ((pop && (out_count == 2'd2)) || (!pop && (out_count == 2'd1)))) begin
      q1 <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= 2'd0;
    end else if (accept && !pop) begin
      out_count <= out_count + 2'd1;
    end else if (pop && !accept) begin
      out_count <= out_count - 2'd1;
    end
  end

  a_send_not_ready: assert property (@(posedge clk) disable iff (rst)
    accept && res.sending |-> !res.ready_to_show)
    else $error("ready_to_show raised while a frame is being sent");

  a_done_ends_frame: assert property (@(posedge clk) disable iff (rst)
    accept && res.frame_done |=> !busy && (latch_count == 16'd0))
    else $error("frame end did not return to idle with a fresh latch gap");

  a_busy_holds: assert property (@(posedge clk) disable iff (rst)
    accept && busy && !res.frame_done |=> busy)
    else $error("frame stopped without its last bit ending");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !busy && (out_count == 2'd0))
    else $error("reset did not clear the frame state and output stage");

endmodule
